@@ sv/bfa_pkg.sv @@
// Package: shared constants and types of the bit field buffer access block.
package bfa_pkg;

	localparam int STORE_BYTES = 64;
	localparam int BYTE_W      = 8;
	localparam int MAX_FIELD   = 32;
	localparam int TOTAL_BITS  = STORE_BYTES * BYTE_W;

	localparam int CMD_W    = 2;
	localparam int OFFSET_W = 9;
	localparam int LENGTH_W = 6;
	localparam int VALUE_W  = 32;

	// offset + length; wide enough for the store size and for the largest request
	localparam int TOT_W = $clog2(TOTAL_BITS + 1);
	localparam int SUM_W = (TOT_W > OFFSET_W + 1) ? TOT_W : OFFSET_W + 1;

	localparam int AW     = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int BIDX_W = OFFSET_W - 3;
	localparam int ASUM_W = (AW > BIDX_W + 1) ? AW : BIDX_W + 1;

	// a field of MAX_FIELD bits at any bit offset spans this many bytes
	localparam int WIN_BYTES = (MAX_FIELD + BYTE_W - 1 + BYTE_W - 1) / BYTE_W;
	localparam int WIN_W     = WIN_BYTES * BYTE_W;
	localparam int CNT_W     = $clog2(WIN_BYTES + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FLIP  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MODIFY,
		ST_WRITE,
		ST_FINISH
	} state_t;

endpackage

@@ sv/bfa_cmd_if.sv @@
// Interface: command channel (valid/ready with the command fields).
interface bfa_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [bfa_pkg::CMD_W-1:0]     cmd;
	logic [bfa_pkg::OFFSET_W-1:0]  offset;
	logic [bfa_pkg::LENGTH_W-1:0]  length;
	logic [bfa_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output cmd, output offset, output length, output value,
		input ready);
	modport sink (input valid, input cmd, input offset, input length, input value,
		output ready);
endinterface

@@ sv/bfa_rsp_if.sv @@
// Interface: response channel (valid/ready with the result fields).
interface bfa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bfa_pkg::MAX_FIELD-1:0] read_value;
	logic                          out_of_range;

	modport source (output valid, output read_value, output out_of_range, input ready);
	modport sink (input valid, input read_value, input out_of_range, output ready);
endinterface

@@ sv/bit_field_buffer_access_top.sv @@
// Bit-addressable byte store with field read, field write, bit flip and clear.
// A command is taken only while the block is idle and gives one response. Reads fetch
// the n bytes a field touches (n = 0..5) one per cycle through the single-port byte
// memory; writes and flips then put the modified bytes back one per cycle. Clear and
// reset act at once through per-byte valid bits; no clearing pass is needed.
module bit_field_buffer_access_top (
	input logic         clk,
	input logic         arst_n,
	bfa_cmd_if.sink     req,
	bfa_rsp_if.source   rsp
);

	localparam int CW = bfa_pkg::CNT_W;

	function automatic logic [bfa_pkg::MAX_FIELD-1:0] rev(
		input logic [bfa_pkg::MAX_FIELD-1:0] x
	);
		logic [bfa_pkg::MAX_FIELD-1:0] r;
		for (int i = 0; i < bfa_pkg::MAX_FIELD; i++) begin
			r[i] = x[bfa_pkg::MAX_FIELD-1-i];
		end
		return r;
	endfunction

	bfa_pkg::state_t state_q, state_d;

	// item registers
	bfa_pkg::cmd_t                    cmd_q;
	logic [2:0]                       s_q;
	logic [bfa_pkg::LENGTH_W-1:0]     len_q;
	logic [bfa_pkg::BIDX_W-1:0]       b0_q;
	logic [CW-1:0]                    n_q;
	logic [bfa_pkg::VALUE_W-1:0]      value_q;
	logic                             err_q;
	logic [bfa_pkg::WIN_W-1:0]        window_q;
	logic [bfa_pkg::MAX_FIELD-1:0]    res_q;
	logic [CW-1:0]                    cnt_q;

	// read pipeline
	logic                             rd_pend_s1;
	logic [CW-1:0]                    rd_idx_s1;

	// memory
	logic [bfa_pkg::BYTE_W-1:0]       mem [bfa_pkg::STORE_BYTES];
	logic [bfa_pkg::BYTE_W-1:0]       mem_rdata_q;
	logic                             vld_rd_q;
	logic [bfa_pkg::STORE_BYTES-1:0]  vld_q;
	logic [bfa_pkg::AW-1:0]           addr;
	logic [bfa_pkg::ASUM_W-1:0]       addr_sum;
	logic                             mem_we;
	logic                             rd_issue;

	// output register
	logic                             out_valid_q;
	logic [bfa_pkg::MAX_FIELD-1:0]    out_value_q;
	logic                             out_oor_q;
	logic                             ld_out;

	// incoming command decode
	bfa_pkg::cmd_t                    in_cmd;
	logic [bfa_pkg::LENGTH_W-1:0]     in_len;
	logic [bfa_pkg::SUM_W-1:0]        in_sum;
	logic                             in_err;
	logic [5:0]                       in_span;
	logic [CW-1:0]                    in_n;
	logic                             accept;

	// modify datapath
	logic [5:0]                       sh;
	logic [bfa_pkg::WIN_W-1:0]        rd_raw;
	logic [bfa_pkg::MAX_FIELD-1:0]    rd_field;
	logic [bfa_pkg::MAX_FIELD-1:0]    wr_bits;
	logic [bfa_pkg::MAX_FIELD-1:0]    wr_mask;
	logic [bfa_pkg::WIN_W-1:0]        win_mask;
	logic [bfa_pkg::WIN_W-1:0]        win_bits;
	logic [bfa_pkg::WIN_W-1:0]        win_new;

	assign accept = req.valid && req.ready;
	assign in_cmd = bfa_pkg::cmd_t'(req.cmd);

	always_comb begin
		if (in_cmd == bfa_pkg::CMD_FLIP) begin
			in_len = bfa_pkg::LENGTH_W'(1);
		end else if (req.length > bfa_pkg::LENGTH_W'(bfa_pkg::MAX_FIELD)) begin
			in_len = bfa_pkg::LENGTH_W'(bfa_pkg::MAX_FIELD);
		end else begin
			in_len = req.length;
		end
	end

	assign in_sum  = bfa_pkg::SUM_W'(req.offset) + bfa_pkg::SUM_W'(in_len);
	assign in_err  = (in_cmd != bfa_pkg::CMD_CLEAR) &&
		(in_sum > bfa_pkg::SUM_W'(bfa_pkg::TOTAL_BITS));
	assign in_span = 6'(req.offset[2:0]) + 6'(in_len) + 6'd7;
	assign in_n    = CW'(in_span[5:3]);

	assign addr_sum = bfa_pkg::ASUM_W'(b0_q) + bfa_pkg::ASUM_W'(cnt_q);
	assign addr     = addr_sum[bfa_pkg::AW-1:0];

	// field alignment: store bit offset+i pairs with value bit length-1-i
	assign sh       = 6'(bfa_pkg::MAX_FIELD) - 6'(len_q);
	assign rd_raw   = window_q >> s_q;
	assign rd_field = rev(rd_raw[bfa_pkg::MAX_FIELD-1:0]) >> sh;
	assign wr_bits  = rev(value_q << sh);
	assign wr_mask  = rev({bfa_pkg::MAX_FIELD{1'b1}} << sh);
	assign win_mask = bfa_pkg::WIN_W'(wr_mask) << s_q;
	assign win_bits = bfa_pkg::WIN_W'(wr_bits) << s_q;

	always_comb begin
		if (cmd_q == bfa_pkg::CMD_FLIP) begin
			win_new = window_q ^ (bfa_pkg::WIN_W'(1) << s_q);
		end else begin
			win_new = (window_q & ~win_mask) | win_bits;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		rd_issue  = 1'b0;
		ld_out    = 1'b0;
		req.ready = 1'b0;
		unique case (state_q)
			bfa_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (in_err || in_cmd == bfa_pkg::CMD_CLEAR || in_len == '0) begin
						state_d = bfa_pkg::ST_FINISH;
					end else begin
						state_d = bfa_pkg::ST_READ;
					end
				end
			end
			bfa_pkg::ST_READ: begin
				if (cnt_q != n_q) begin
					rd_issue = 1'b1;
				end else if (!rd_pend_s1) begin
					state_d = bfa_pkg::ST_MODIFY;
				end
			end
			bfa_pkg::ST_MODIFY: begin
				if (cmd_q == bfa_pkg::CMD_READ) begin
					state_d = bfa_pkg::ST_FINISH;
				end else begin
					state_d = bfa_pkg::ST_WRITE;
				end
			end
			bfa_pkg::ST_WRITE: begin
				mem_we = 1'b1;
				if (cnt_q == n_q - CW'(1)) begin
					state_d = bfa_pkg::ST_FINISH;
				end
			end
			bfa_pkg::ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					ld_out  = 1'b1;
					state_d = bfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bfa_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_pend_s1  <= 1'b0;
			rd_idx_s1   <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_issue;
			rd_idx_s1  <= cnt_q;
			if (accept || state_q == bfa_pkg::ST_MODIFY) begin
				cnt_q <= '0;
			end else if (rd_issue || mem_we) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (accept && in_cmd == bfa_pkg::CMD_CLEAR) begin
				vld_q <= '0;
			end else if (mem_we) begin
				vld_q[addr] <= 1'b1;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and window registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= in_cmd;
			s_q      <= req.offset[2:0];
			len_q    <= in_len;
			b0_q     <= req.offset[bfa_pkg::OFFSET_W-1:3];
			n_q      <= in_n;
			value_q  <= req.value;
			err_q    <= in_err;
			window_q <= '0;
			res_q    <= '0;
		end else begin
			if (rd_pend_s1) begin
				window_q[{rd_idx_s1, 3'b000} +: bfa_pkg::BYTE_W] <=
					vld_rd_q ? mem_rdata_q : '0;
			end
			if (state_q == bfa_pkg::ST_MODIFY) begin
				window_q <= win_new;
				if (cmd_q == bfa_pkg::CMD_READ) begin
					res_q <= rd_field;
				end
			end
		end
		if (ld_out) begin
			out_value_q <= res_q;
			out_oor_q   <= err_q;
		end
	end

	// byte memory, one access per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= window_q[{cnt_q, 3'b000} +: bfa_pkg::BYTE_W];
		end
		mem_rdata_q <= mem[addr];
		vld_rd_q    <= vld_q[addr];
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_value   = out_value_q;
	assign rsp.out_of_range = out_oor_q;

	a_no_write_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfa_pkg::ST_WRITE) |-> !err_q)
		else $error("store written for an out-of-range command");

	a_write_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfa_pkg::ST_WRITE) |-> (cnt_q < n_q))
		else $error("write past the bytes of the field");

	a_read_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (rd_idx_s1 < n_q))
		else $error("read data lands outside the window");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_cmd == bfa_pkg::CMD_CLEAR) |=> (vld_q == '0))
		else $error("clear left bytes valid");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |=> (out_valid_q && state_q == bfa_pkg::ST_IDLE))
		else $error("response not presented after finish");

endmodule
